// File: rtl/hd_pkg.sv
// Shared constants, widths and the arctangent table for the haversine distance pipeline.
package hd_pkg;

   localparam int LAT_W    = 24;
   localparam int LON_W    = 25;
   localparam int DIST_W   = 25;
   localparam int RADIUS_W = 23;
   localparam int DIFF_W   = 26;

   localparam int ANGLE_FRAC_BITS_DEF = 16;
   localparam int CORDIC_STAGES_DEF   = 24;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd6371000;

   // degrees to Q32 turns scale, floor((2^39 + 180) / 360)
   localparam logic signed [31:0] TURN_MULT = 32'sd1527099483;
   localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
   localparam logic [31:0] FOUR_PI_Q28 = 32'd3373259426;
   localparam logic [30:0] Q30_ONE = 31'h4000_0000;
   localparam logic [31:0] U_MAX = 32'd3373259426;

   // CSR address of the radius register
   localparam logic [2:0] ADDR_RADIUS = 3'd0;

   // arctangent of 2^-i in Q32 turns
   function automatic logic signed [32:0] atan_turn(input int i);
      logic signed [32:0] v;
      case (i)
         0:  v = 33'sd536870912;
         1:  v = 33'sd316933406;
         2:  v = 33'sd167458907;
         3:  v = 33'sd85004756;
         4:  v = 33'sd42667331;
         5:  v = 33'sd21354465;
         6:  v = 33'sd10679838;
         7:  v = 33'sd5340245;
         8:  v = 33'sd2670163;
         9:  v = 33'sd1335087;
         10: v = 33'sd667544;
         11: v = 33'sd333772;
         12: v = 33'sd166886;
         13: v = 33'sd83443;
         14: v = 33'sd41722;
         15: v = 33'sd20861;
         16: v = 33'sd10430;
         17: v = 33'sd5215;
         18: v = 33'sd2608;
         19: v = 33'sd1304;
         20: v = 33'sd652;
         21: v = 33'sd326;
         22: v = 33'sd163;
         23: v = 33'sd81;
         24: v = 33'sd41;
         25: v = 33'sd20;
         26: v = 33'sd10;
         27: v = 33'sd5;
         28: v = 33'sd3;
         29: v = 33'sd1;
         30: v = 33'sd1;
         default: v = 33'sd0;
      endcase
      return v;
   endfunction

endpackage

// File: rtl/hd_rot_cordic.sv
// Pipelined rotation CORDIC: sine and cosine of a Q32 turn angle in Q30.
module hd_rot_cordic #(
   parameter int STAGES = hd_pkg::CORDIC_STAGES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [31:0]        in_angle,
   output logic               out_valid,
   output logic signed [31:0] out_sin,
   output logic signed [31:0] out_cos
);

   logic signed [32:0] x_ff [0:STAGES];
   logic signed [32:0] y_ff [0:STAGES];
   logic signed [32:0] z_ff [0:STAGES];
   logic [1:0]         q_ff [0:STAGES];
   logic               v_ff [0:STAGES];
   logic               out_valid_ff;
   logic signed [31:0] sin_ff;
   logic signed [31:0] cos_ff;

   // load the first stage, split off the quadrant
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      x_ff[0] <= hd_pkg::CORDIC_GAIN;
      y_ff[0] <= '0;
      z_ff[0] <= {3'b000, in_angle[29:0]};
      q_ff[0] <= in_angle[31:30];
   end

   // rotate one micro-step per stage
   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else begin
            v_ff[i+1] <= v_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         q_ff[i+1] <= q_ff[i];
         if (z_ff[i] >= 0) begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - hd_pkg::atan_turn(i);
         end else begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + hd_pkg::atan_turn(i);
         end
      end
   end

   // map the quadrant back onto sine and cosine
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= v_ff[STAGES];
      end
   end

   always_ff @(posedge clock) begin
      case (q_ff[STAGES])
         2'd0: begin
            cos_ff <= 32'(x_ff[STAGES]);
            sin_ff <= 32'(y_ff[STAGES]);
         end
         2'd1: begin
            cos_ff <= 32'(-y_ff[STAGES]);
            sin_ff <= 32'(x_ff[STAGES]);
         end
         2'd2: begin
            cos_ff <= 32'(-x_ff[STAGES]);
            sin_ff <= 32'(-y_ff[STAGES]);
         end
         default: begin
            cos_ff <= 32'(y_ff[STAGES]);
            sin_ff <= 32'(-x_ff[STAGES]);
         end
      endcase
   end

   assign out_valid = out_valid_ff;
   assign out_sin   = sin_ff;
   assign out_cos   = cos_ff;

endmodule

// File: rtl/hd_isqrt.sv
// Pipelined square root: floor(sqrt(v * 2^30)) for a Q30 value, one root bit per stage.
module hd_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [30:0] in_value,
   output logic        out_valid,
   output logic [30:0] out_root
);

   localparam int BITS = 31;

   logic [60:0] rem_ff  [0:BITS];
   logic [30:0] root_ff [0:BITS];
   logic        v_ff    [0:BITS];

   // load the scaled value
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= {in_value, 30'd0};
      root_ff[0] <= '0;
   end

   // decide root bit k = BITS-1-j in stage j
   for (genvar j = 0; j < BITS; j++) begin : g_bit
      localparam int K = BITS - 1 - j;
      logic [62:0] trial;

      assign trial = ({32'd0, root_ff[j]} << (K + 1)) + (63'd1 << (2 * K));

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j+1] <= 1'b0;
         end else begin
            v_ff[j+1] <= v_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if ({2'b00, rem_ff[j]} >= trial) begin
            rem_ff[j+1]  <= 61'({2'b00, rem_ff[j]} - trial);
            root_ff[j+1] <= root_ff[j] | (31'd1 << K);
         end else begin
            rem_ff[j+1]  <= rem_ff[j];
            root_ff[j+1] <= root_ff[j];
         end
      end
   end

   assign out_valid = v_ff[BITS];
   assign out_root  = root_ff[BITS];

endmodule

// File: rtl/hd_vec_cordic.sv
// Pipelined vectoring CORDIC: angle of (x, y) in Q32 turns, clamped to a quarter turn.
module hd_vec_cordic #(
   parameter int STAGES = hd_pkg::CORDIC_STAGES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [30:0] in_x,
   input  logic [30:0] in_y,
   output logic        out_valid,
   output logic [30:0] out_angle
);

   logic signed [32:0] x_ff [0:STAGES];
   logic signed [32:0] y_ff [0:STAGES];
   logic signed [33:0] z_ff [0:STAGES];
   logic               v_ff [0:STAGES];
   logic               out_valid_ff;
   logic [30:0]        angle_ff;

   // load the vector
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      x_ff[0] <= {2'b00, in_x};
      y_ff[0] <= {2'b00, in_y};
      z_ff[0] <= '0;
   end

   // drive y toward zero, one micro-step per stage
   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else begin
            v_ff[i+1] <= v_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (y_ff[i] >= 0) begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + 34'(hd_pkg::atan_turn(i));
         end else begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - 34'(hd_pkg::atan_turn(i));
         end
      end
   end

   // clamp the angle to 0..quarter turn
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= v_ff[STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (z_ff[STAGES] < 0) begin
         angle_ff <= '0;
      end else if (z_ff[STAGES] > $signed({3'b000, hd_pkg::Q30_ONE})) begin
         angle_ff <= hd_pkg::Q30_ONE;
      end else begin
         angle_ff <= 31'(z_ff[STAGES]);
      end
   end

   assign out_valid = out_valid_ff;
   assign out_angle = angle_ff;

endmodule

// File: rtl/haversine_distance.sv
// Top level of the haversine great-circle distance pipeline with its radius register.
//
// Takes one point pair per cycle whenever start is high; busy is always low and the block
// never stalls. Each item gives one distance on rsp_distance_m, marked by a one-cycle
// rsp_strobe, in the order the items came in. The pipeline depth is set by the two CORDIC
// pipelines (one stage per micro-rotation) and the 31-stage square root, one result bit per
// stage. The radius register sits at byte address 0 and must be written only while no item
// is in flight.
module haversine_distance #(
   parameter int ANGLE_FRAC_BITS = hd_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int CORDIC_STAGES   = hd_pkg::CORDIC_STAGES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [hd_pkg::LAT_W-1:0]    req_first_latitude,
   input  logic signed [hd_pkg::LON_W-1:0]    req_first_longitude,
   input  logic signed [hd_pkg::LAT_W-1:0]    req_second_latitude,
   input  logic signed [hd_pkg::LON_W-1:0]    req_second_longitude,
   output logic                               rsp_strobe,
   output logic [hd_pkg::DIST_W-1:0]          rsp_distance_m,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [2:0]                         paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);

   localparam int FULL_SH = ANGLE_FRAC_BITS + 7;
   localparam int HALF_SH = ANGLE_FRAC_BITS + 8;

   // radius register
   logic [hd_pkg::RADIUS_W-1:0] radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= hd_pkg::RADIUS_RESET;
      end else if (psel && penable && pwrite && paddr == hd_pkg::ADDR_RADIUS) begin
         radius_ff <= pwdata[hd_pkg::RADIUS_W-1:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr == hd_pkg::ADDR_RADIUS) ? {9'd0, radius_ff} : 32'd0;
   assign busy   = 1'b0;

   // register coordinates and differences
   logic                             in_v_ff;
   logic signed [hd_pkg::DIFF_W-1:0] lat1_ff, lat2_ff, dlat_ff, dlon_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else begin
         in_v_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      lat1_ff <= hd_pkg::DIFF_W'(req_first_latitude);
      lat2_ff <= hd_pkg::DIFF_W'(req_second_latitude);
      dlat_ff <= hd_pkg::DIFF_W'(req_second_latitude) - hd_pkg::DIFF_W'(req_first_latitude);
      dlon_ff <= hd_pkg::DIFF_W'(req_second_longitude) - hd_pkg::DIFF_W'(req_first_longitude);
   end

   // scale degrees to Q32 turns with rounding
   logic signed [63:0] p_lat1, p_lat2, p_dlat, p_dlon;
   logic               turn_v_ff;
   logic [31:0]        t_lat1_ff, t_lat2_ff, t_dlat_ff, t_dlon_ff;

   always_comb begin
      p_lat1 = 64'(lat1_ff * hd_pkg::TURN_MULT) + (64'sd1 <<< (FULL_SH - 1));
      p_lat2 = 64'(lat2_ff * hd_pkg::TURN_MULT) + (64'sd1 <<< (FULL_SH - 1));
      p_dlat = 64'(dlat_ff * hd_pkg::TURN_MULT) + (64'sd1 <<< (HALF_SH - 1));
      p_dlon = 64'(dlon_ff * hd_pkg::TURN_MULT) + (64'sd1 <<< (HALF_SH - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         turn_v_ff <= 1'b0;
      end else begin
         turn_v_ff <= in_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      t_lat1_ff <= p_lat1[FULL_SH+31 -: 32];
      t_lat2_ff <= p_lat2[FULL_SH+31 -: 32];
      t_dlat_ff <= p_dlat[HALF_SH+31 -: 32];
      t_dlon_ff <= p_dlon[HALF_SH+31 -: 32];
   end

   // sine and cosine of the four angles
   logic               trig_v;
   logic signed [31:0] s_dlat, s_dlon, c_lat1, c_lat2;

   hd_rot_cordic #(.STAGES(CORDIC_STAGES)) u_rot_dlat (
      .clock(clock), .reset(reset), .in_valid(turn_v_ff), .in_angle(t_dlat_ff),
      .out_valid(trig_v), .out_sin(s_dlat), .out_cos()
   );

   hd_rot_cordic #(.STAGES(CORDIC_STAGES)) u_rot_dlon (
      .clock(clock), .reset(reset), .in_valid(turn_v_ff), .in_angle(t_dlon_ff),
      .out_valid(), .out_sin(s_dlon), .out_cos()
   );

   hd_rot_cordic #(.STAGES(CORDIC_STAGES)) u_rot_lat1 (
      .clock(clock), .reset(reset), .in_valid(turn_v_ff), .in_angle(t_lat1_ff),
      .out_valid(), .out_sin(), .out_cos(c_lat1)
   );

   hd_rot_cordic #(.STAGES(CORDIC_STAGES)) u_rot_lat2 (
      .clock(clock), .reset(reset), .in_valid(turn_v_ff), .in_angle(t_lat2_ff),
      .out_valid(), .out_sin(), .out_cos(c_lat2)
   );

   // first products: squares of the half differences, product of cosines
   logic signed [63:0] p_sq_lat, p_sq_lon, p_cc;
   logic               m1_v_ff;
   logic signed [31:0] sq_lat_ff, sq_lon_ff, cc_ff;

   always_comb begin
      p_sq_lat = s_dlat * s_dlat;
      p_sq_lon = s_dlon * s_dlon;
      p_cc     = c_lat1 * c_lat2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_v_ff <= 1'b0;
      end else begin
         m1_v_ff <= trig_v;
      end
   end

   always_ff @(posedge clock) begin
      sq_lat_ff <= 32'(p_sq_lat >>> 30);
      sq_lon_ff <= 32'(p_sq_lon >>> 30);
      cc_ff     <= 32'(p_cc >>> 30);
   end

   // second product: cosine term times longitude square
   logic signed [63:0] p_lon_term;
   logic               m2_v_ff;
   logic signed [31:0] lat_term_ff, lon_term_ff;

   assign p_lon_term = cc_ff * sq_lon_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_v_ff <= 1'b0;
      end else begin
         m2_v_ff <= m1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      lat_term_ff <= sq_lat_ff;
      lon_term_ff <= 32'(p_lon_term >>> 30);
   end

   // sum and clamp a to 0..1
   logic signed [32:0] a_sum;
   logic               a_v_ff;
   logic [30:0]        a_ff, one_minus_a_ff;
   logic [30:0]        a_clamped;

   always_comb begin
      a_sum = 33'(lat_term_ff) + 33'(lon_term_ff);
      if (a_sum < 0) begin
         a_clamped = '0;
      end else if (a_sum > $signed({2'b00, hd_pkg::Q30_ONE})) begin
         a_clamped = hd_pkg::Q30_ONE;
      end else begin
         a_clamped = 31'(a_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else begin
         a_v_ff <= m2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ff           <= a_clamped;
      one_minus_a_ff <= hd_pkg::Q30_ONE - a_clamped;
   end

   // square roots of a and 1 - a
   logic        sqrt_v;
   logic [30:0] root_a, root_b;

   hd_isqrt u_sqrt_a (
      .clock(clock), .reset(reset), .in_valid(a_v_ff), .in_value(a_ff),
      .out_valid(sqrt_v), .out_root(root_a)
   );

   hd_isqrt u_sqrt_b (
      .clock(clock), .reset(reset), .in_valid(a_v_ff), .in_value(one_minus_a_ff),
      .out_valid(), .out_root(root_b)
   );

   // half central angle
   logic        t_v;
   logic [30:0] t_angle;

   hd_vec_cordic #(.STAGES(CORDIC_STAGES)) u_vec (
      .clock(clock), .reset(reset), .in_valid(sqrt_v), .in_x(root_b), .in_y(root_a),
      .out_valid(t_v), .out_angle(t_angle)
   );

   // central angle in radians, Q30
   logic [62:0] p_u;
   logic        u_v_ff;
   logic [31:0] u_ff;

   assign p_u = t_angle * hd_pkg::FOUR_PI_Q28 + (63'd1 << 29);

   always_ff @(posedge clock) begin
      if (reset) begin
         u_v_ff <= 1'b0;
      end else begin
         u_v_ff <= t_v;
      end
   end

   always_ff @(posedge clock) begin
      u_ff <= 32'(p_u >> 30);
   end

   // scale by the radius and round to meters
   logic [54:0]                p_dist;
   logic                       dist_v_ff;
   logic [hd_pkg::DIST_W-1:0]  dist_ff;

   assign p_dist = radius_ff * u_ff + (55'd1 << 29);

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_v_ff <= 1'b0;
      end else begin
         dist_v_ff <= u_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff <= p_dist[30 +: hd_pkg::DIST_W];
   end

   assign rsp_strobe     = dist_v_ff;
   assign rsp_distance_m = dist_ff;

`ifndef SYNTHESIS
   a_a_range: assert property (@(posedge clock) disable iff (reset)
      a_v_ff |-> (a_ff + one_minus_a_ff == hd_pkg::Q30_ONE))
      else $error("a and 1 - a do not sum to one");

   a_u_range: assert property (@(posedge clock) disable iff (reset)
      u_v_ff |-> (u_ff <= hd_pkg::U_MAX))
      else $error("central angle beyond half a turn");

   a_strobe_follow: assert property (@(posedge clock) disable iff (reset)
      u_v_ff |=> rsp_strobe)
      else $error("scaled item lost before the result strobe");

   a_angle_clamp: assert property (@(posedge clock) disable iff (reset)
      t_v |-> (t_angle <= hd_pkg::Q30_ONE))
      else $error("half angle beyond a quarter turn");
`endif

endmodule

// File: sim/testbench.sv
// Testbench for the haversine distance pipeline: random and directed point pairs, scoreboarded.
`timescale 1ns / 100ps

class distance_board;
   logic [hd_pkg::DIST_W-1:0] pending_q[$];
   int errors;

   function new();
      errors = 0;
   endfunction

   // note an expected distance for an accepted item
   function void note_item(logic [hd_pkg::DIST_W-1:0] d);
      pending_q.push_back(d);
   endfunction

   // compare a result with the oldest expected distance
   function void check_distance(logic [hd_pkg::DIST_W-1:0] got);
      logic [hd_pkg::DIST_W-1:0] want;
      if (pending_q.size() == 0) begin
         $display("%0t: unexpected distance %0d", $time, got);
         errors++;
      end else begin
         want = pending_q.pop_front();
         if (want !== got) begin
            $display("%0t: distance_m expected %0d actual %0d", $time, want, got);
            errors++;
         end
      end
   endfunction
endclass

module testbench;

   localparam int LATENCY = 2 * hd_pkg::CORDIC_STAGES_DEF + 43;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam longint TURN_M = 64'd1527099483;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic signed [hd_pkg::LAT_W-1:0] req_first_latitude = '0, req_second_latitude = '0;
   logic signed [hd_pkg::LON_W-1:0] req_first_longitude = '0, req_second_longitude = '0;
   logic rsp_strobe;
   logic [hd_pkg::DIST_W-1:0] rsp_distance_m;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   distance_board board = new();
   logic [hd_pkg::RADIUS_W-1:0] radius_m;
   int idle_pct;
   int quiet_cycles;

   haversine_distance u_top (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   function automatic longint floor_shift(longint v, int n);
      return v >>> n;
   endfunction

   // degrees in Q16 to Q32 turns, rounded
   function automatic logic [31:0] deg_to_turns(longint v, int shift);
      logic [63:0] p;
      p = v * TURN_M + (64'd1 << (shift - 1));
      return p[shift +: 32];
   endfunction

   // rotation CORDIC with quadrant reduction
   task automatic rotate(input logic [31:0] ang, output longint s, output longint c);
      longint x, y, z, dx, dy;
      x = hd_pkg::CORDIC_GAIN;
      y = 0;
      z = ang[29:0];
      for (int i = 0; i < hd_pkg::CORDIC_STAGES_DEF; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= hd_pkg::atan_turn(i);
         end else begin
            x += dx; y -= dy; z += hd_pkg::atan_turn(i);
         end
      end
      case (ang[31:30])
         2'd0: begin c = x; s = y; end
         2'd1: begin c = -y; s = x; end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endtask

   function automatic longint int_sqrt(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // predict the rounded great-circle distance
   task automatic predict_distance(input longint lat1, lon1, lat2, lon2,
                                   output logic [hd_pkg::DIST_W-1:0] d);
      longint sdl, cdl, sdo, cdo, s1, c1, s2, c2, a, x, y, z, dx, dy;
      logic [63:0] u, dist_full;
      rotate(deg_to_turns(lat2 - lat1, hd_pkg::ANGLE_FRAC_BITS_DEF + 8), sdl, cdl);
      rotate(deg_to_turns(lon2 - lon1, hd_pkg::ANGLE_FRAC_BITS_DEF + 8), sdo, cdo);
      rotate(deg_to_turns(lat1, hd_pkg::ANGLE_FRAC_BITS_DEF + 7), s1, c1);
      rotate(deg_to_turns(lat2, hd_pkg::ANGLE_FRAC_BITS_DEF + 7), s2, c2);
      a = floor_shift(sdl * sdl, 30)
          + floor_shift(floor_shift(c1 * c2, 30) * floor_shift(sdo * sdo, 30), 30);
      if (a < 0) a = 0;
      if (a > (64'sd1 << 30)) a = 64'sd1 << 30;
      x = int_sqrt(((64'd1 << 30) - a) << 30);
      y = int_sqrt(a << 30);
      z = 0;
      for (int i = 0; i < hd_pkg::CORDIC_STAGES_DEF; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (y >= 0) begin
            x += dx; y -= dy; z += hd_pkg::atan_turn(i);
         end else begin
            x -= dx; y += dy; z -= hd_pkg::atan_turn(i);
         end
      end
      if (z < 0) z = 0;
      if (z > (64'sd1 << 30)) z = 64'sd1 << 30;
      u = (z * hd_pkg::FOUR_PI_Q28 + (64'd1 << 29)) >> 30;
      dist_full = (radius_m * u + (64'd1 << 29)) >> 30;
      d = dist_full[hd_pkg::DIST_W-1:0];
   endtask

   // check each strobed distance
   always @(posedge clock) begin
      if (!reset && rsp_strobe) board.check_distance(rsp_distance_m);
   end

   // stop the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || start || rsp_strobe) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // write the radius register with a setup and an access phase
   task automatic write_radius(input logic [hd_pkg::RADIUS_W-1:0] r);
      psel <= 1; pwrite <= 1; penable <= 0; paddr <= hd_pkg::ADDR_RADIUS; pwdata <= 32'(r);
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      radius_m = r;
   endtask

   // hold until the pipeline has drained
   task automatic drain();
      while (board.pending_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // offer one point pair and note its distance on acceptance
   task automatic send_pair(input longint lat1, lon1, lat2, lon2);
      logic [hd_pkg::DIST_W-1:0] d;
      while ($urandom_range(99) < idle_pct) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1;
      req_first_latitude <= lat1[hd_pkg::LAT_W-1:0];
      req_first_longitude <= lon1[hd_pkg::LON_W-1:0];
      req_second_latitude <= lat2[hd_pkg::LAT_W-1:0];
      req_second_longitude <= lon2[hd_pkg::LON_W-1:0];
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_distance(longint'(req_first_latitude), longint'(req_first_longitude),
                       longint'(req_second_latitude), longint'(req_second_longitude), d);
      board.note_item(d);
   endtask

   function automatic longint rand_field(int w, longint hi);
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) return -hi;
      if (pick == 1) return hi;
      if (pick == 2) return longint'($urandom_range(2 ** (w - 1) - 1)) - 2 ** (w - 1) / 2;
      if (pick == 3) return longint'($urandom) % (2 ** w) - 2 ** (w - 1);
      return longint'($urandom_range(2 * hi)) - hi;
   endfunction

   task automatic random_pairs(input int n);
      longint la, lo;
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(3) == 0) begin
            // nearby points: small differences
            la = rand_field(24, 5898240);
            lo = rand_field(25, 11796480);
            send_pair(la, lo, la + longint'($urandom_range(2000)) - 1000,
                      lo + longint'($urandom_range(2000)) - 1000);
         end else begin
            send_pair(rand_field(24, 5898240), rand_field(25, 11796480),
                      rand_field(24, 5898240), rand_field(25, 11796480));
         end
      end
      start <= 0;
   endtask

   localparam longint LAT_MAX = 5898240, LON_MAX = 11796480;

   initial begin
      radius_m = hd_pkg::RADIUS_RESET;
      idle_pct = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, antipodes, coincident points, wrap of field ranges
      send_pair(0, 0, 0, 0);
      send_pair(LAT_MAX, 0, -LAT_MAX, 0);
      send_pair(0, 0, 0, LON_MAX);
      send_pair(0, -LON_MAX, 0, LON_MAX);
      send_pair(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
      send_pair(-LAT_MAX, 123, -LAT_MAX, 99999);
      send_pair(1, 1, 0, 0);
      send_pair(-8388608, -16777216, 8388607, 16777215);
      send_pair(8388607, 16777215, -8388608, -16777216);
      send_pair(2949120, 5898240, -2949120, -5898240);
      send_pair(3276800, 1000, 3276801, 1001);
      send_pair(0, 0, 1, 0);
      send_pair(-1, -1, -1, -1);
      send_pair(0, LON_MAX, 0, -LON_MAX + 1);
      start <= 0;
      drain();

      write_radius(8388607);
      idle_pct = 0;
      send_pair(0, 0, 0, LON_MAX);
      send_pair(LAT_MAX, 0, -LAT_MAX, 0);
      random_pairs(150);
      drain();

      write_radius(1);
      idle_pct = 86;
      random_pairs(100);
      drain();

      write_radius(0);
      send_pair(0, 0, 0, LON_MAX);
      start <= 0;
      drain();

      write_radius(hd_pkg::RADIUS_RESET);
      idle_pct = 31;
      random_pairs(200);
      drain();

      write_radius(23'($urandom_range(8388607, 1)));
      idle_pct = 0;
      random_pairs(150);
      drain();

      write_radius(1000);
      idle_pct = 86;
      random_pairs(150);
      drain();

      if (board.errors == 0 && board.pending_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
